[hw/rtl/rtcd_pkg.sv]
// Shared types, constants and helper functions for the clock-chip date/time decoder.
package rtcd_pkg;

  // Hour-byte flag and masks.
  localparam logic [7:0] HourPmBit   = 8'h80;
  localparam logic [7:0] HourMask12  = 8'h7F;

  // Year forming constants.
  localparam logic [14:0] CenturyWeight = 15'd100;
  localparam logic [14:0] DefaultYear   = 15'd2000;
  localparam logic [7:0]  DefaultCent   = 8'd20;

  // Range limits.
  localparam logic [7:0] MaxHour   = 8'd23;
  localparam logic [7:0] MaxMinute = 8'd59;
  localparam logic [7:0] MaxSecond = 8'd59;
  localparam logic [7:0] MaxMonth  = 8'd12;
  localparam logic [7:0] MaxDay    = 8'd31;
  localparam logic [7:0] NoonHour  = 8'd12;

  // Register bytes after the PM strip and BCD conversion.
  typedef struct packed {
    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hr;
    logic [7:0] dy;
    logic [7:0] mon;
    logic [7:0] yr;
    logic [7:0] cent;
  } dec_t;

  // Full year, leap flag and pre-checked calendar fields.
  typedef struct packed {
    logic [14:0] fy;
    logic        leap;
    logic        mon_ok;
    logic [3:0]  mon;
    logic        dy_ok;
    logic [4:0]  dy;
    logic        time_ok;
    logic [4:0]  hr;
    logic [5:0]  min;
    logic [5:0]  sec;
  } yr_t;

  // Final result item.
  typedef struct packed {
    logic        ok;
    logic [14:0] cal_year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } res_t;

  // Weight each nibble as it stands: high times ten plus low.
  function automatic logic [7:0] nibble_weight(input logic [7:0] v);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'b0, v[7:4]};
    lo = {4'b0, v[3:0]};
    return (hi << 3) + (hi << 1) + lo;
  endfunction

  // Days in a month that is already known to lie in 1..12.
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      4'd2:                      d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

[hw/rtl/rtcd_decode.sv]
// First stage: PM strip, BCD conversion and 12-to-24-hour mapping.
module rtcd_decode import rtcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [55:0] raw_i,
  input  logic        binary_format_i,
  input  logic        hour_24_i,
  output logic        valid_o,
  input  logic        ready_i,
  output dec_t        data_o
);

  logic       valid_q;
  dec_t       data_q;
  dec_t       data_d;
  logic       pm;
  logic [7:0] hr_raw;
  dec_t       conv;

  assign ready_o = !valid_q || ready_i;

  // Strip the PM flag, convert from BCD and map the hour to 24-hour form.
  always_comb begin
    pm     = !hour_24_i && ((raw_i[23:16] & HourPmBit) != 8'd0);
    hr_raw = hour_24_i ? raw_i[23:16] : (raw_i[23:16] & HourMask12);
    conv.sec  = raw_i[7:0];
    conv.min  = raw_i[15:8];
    conv.hr   = hr_raw;
    conv.dy   = raw_i[31:24];
    conv.mon  = raw_i[39:32];
    conv.yr   = raw_i[47:40];
    conv.cent = raw_i[55:48];
    if (!binary_format_i) begin
      conv.sec  = nibble_weight(raw_i[7:0]);
      conv.min  = nibble_weight(raw_i[15:8]);
      conv.hr   = nibble_weight(hr_raw);
      conv.dy   = nibble_weight(raw_i[31:24]);
      conv.mon  = nibble_weight(raw_i[39:32]);
      conv.yr   = nibble_weight(raw_i[47:40]);
      conv.cent = nibble_weight(raw_i[55:48]);
    end
    data_d = conv;
    if (!hour_24_i) begin
      if (pm) begin
        if (conv.hr < NoonHour) data_d.hr = conv.hr + NoonHour;
      end else if (conv.hr == NoonHour) begin
        data_d.hr = 8'd0;
      end
    end
  end

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[hw/rtl/rtcd_year.sv]
// Second stage: full year, leap flag and the simple range checks.
module rtcd_year import rtcd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  dec_t data_i,
  output logic valid_o,
  input  logic ready_i,
  output yr_t  data_o
);

  logic       valid_q;
  yr_t        data_q;
  yr_t        data_d;
  logic       cent_nz;
  logic [1:0] yr_div;
  logic [7:0] yr_mod;
  logic [1:0] base;
  logic [1:0] cent_lo;

  assign ready_o = !valid_q || ready_i;

  // The century only adds multiples of 100, so the year byte alone decides
  // the divisible-by-4 and by-100 tests; the by-400 test looks at the
  // century count plus the hundreds carried in the year byte.
  always_comb begin
    cent_nz = data_i.cent != 8'd0;
    if (data_i.yr >= 8'd200) begin
      yr_div = 2'd2;
      yr_mod = data_i.yr - 8'd200;
    end else if (data_i.yr >= 8'd100) begin
      yr_div = 2'd1;
      yr_mod = data_i.yr - 8'd100;
    end else begin
      yr_div = 2'd0;
      yr_mod = data_i.yr;
    end
    base    = cent_nz ? data_i.cent[1:0] : DefaultCent[1:0];
    cent_lo = base + yr_div;

    data_d.fy   = cent_nz ? ({7'b0, data_i.cent} * CenturyWeight) + {7'b0, data_i.yr}
                          : DefaultYear + {7'b0, data_i.yr};
    data_d.leap = (yr_mod == 8'd0) ? (cent_lo == 2'd0) : (data_i.yr[1:0] == 2'd0);

    data_d.mon_ok  = (data_i.mon >= 8'd1) && (data_i.mon <= MaxMonth);
    data_d.mon     = data_i.mon[3:0];
    data_d.dy_ok   = (data_i.dy >= 8'd1) && (data_i.dy <= MaxDay);
    data_d.dy      = data_i.dy[4:0];
    data_d.time_ok = (data_i.hr <= MaxHour) && (data_i.min <= MaxMinute) &&
                     (data_i.sec <= MaxSecond);
    data_d.hr      = data_i.hr[4:0];
    data_d.min     = data_i.min[5:0];
    data_d.sec     = data_i.sec[5:0];
  end

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[hw/rtl/rtcd_check.sv]
// Third stage: day against month length, final flag and zeroing, output register.
module rtcd_check import rtcd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  yr_t  data_i,
  output logic valid_o,
  input  logic ready_i,
  output res_t data_o
);

  logic       valid_q;
  res_t       data_q;
  res_t       data_d;
  logic [4:0] dim;
  logic       good;

  assign ready_o = !valid_q || ready_i;

  // Compare the day with the month length and clear everything on failure.
  always_comb begin
    dim  = month_days(data_i.mon, data_i.leap);
    good = data_i.mon_ok && data_i.dy_ok && (data_i.dy <= dim) && data_i.time_ok;
    data_d.ok        = good;
    data_d.cal_year  = good ? data_i.fy  : 15'd0;
    data_d.month     = good ? data_i.mon : 4'd0;
    data_d.day       = good ? data_i.dy  : 5'd0;
    data_d.hour      = good ? data_i.hr  : 5'd0;
    data_d.minute    = good ? data_i.min : 6'd0;
    data_d.second    = good ? data_i.sec : 6'd0;
  end

  // Output valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[hw/rtl/rtc_register_datetime_decode.sv]
// Top level of the clock-chip date/time register decoder.
// Each request is one snapshot of the seven raw time registers with the
// binary-format and 24-hour mode flags; each produces exactly one result with
// an ok flag and the decoded year, month, day, hour, minute and second (all
// zero when ok is low). The block is a three-stage pipeline (decode, year and
// leap, final check) that takes one request per cycle while the output side
// is not stalled; each result is registered in each stage in turn and is
// presented on the output from the final check register.
// Each stage holds while its successor is full and stalled, so backpressure
// loses and repeats nothing.
module rtc_register_datetime_decode import rtcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // raw_second, raw_minute, raw_hour, raw_day, raw_month, raw_year, raw_century
  input  logic [55:0] s_axis_tdata,
  // binary_format, hour_24
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // cal_year, month, day, hour, minute, second, zero pad
  output logic [47:0] m_axis_tdata,
  // ok
  output logic        m_axis_tuser
);

  logic dec_valid;
  logic dec_ready;
  dec_t dec_data;
  logic yr_valid;
  logic yr_ready;
  yr_t  yr_data;
  res_t res;

  // Stage one: register decode.
  rtcd_decode u_decode (
    .clk_i,
    .rst_ni,
    .valid_i         (s_axis_tvalid),
    .ready_o         (s_axis_tready),
    .raw_i           (s_axis_tdata),
    .binary_format_i (s_axis_tuser[0]),
    .hour_24_i       (s_axis_tuser[1]),
    .valid_o         (dec_valid),
    .ready_i         (dec_ready),
    .data_o          (dec_data)
  );

  // Stage two: year and leap.
  rtcd_year u_year (
    .clk_i,
    .rst_ni,
    .valid_i (dec_valid),
    .ready_o (dec_ready),
    .data_i  (dec_data),
    .valid_o (yr_valid),
    .ready_i (yr_ready),
    .data_o  (yr_data)
  );

  // Stage three: final check and output register.
  rtcd_check u_check (
    .clk_i,
    .rst_ni,
    .valid_i (yr_valid),
    .ready_o (yr_ready),
    .data_i  (yr_data),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (res)
  );

  // Pack the result fields, first field lowest.
  assign m_axis_tdata = {7'b0, res.second, res.minute, res.hour, res.day, res.month,
                         res.cal_year};
  assign m_axis_tuser = res.ok;

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the clock-chip date/time register decoder.
`timescale 1ns / 1ps

module tb_top;

  // Mode flags as carried on s_axis_tuser: bit 0 binary format, bit 1 24-hour.
  localparam logic [1:0] BcdHour12 = 2'b00;
  localparam logic [1:0] BinHour12 = 2'b01;
  localparam logic [1:0] BcdHour24 = 2'b10;
  localparam logic [1:0] BinHour24 = 2'b11;

  localparam logic [7:0] PmFlag    = 8'h80;
  localparam logic [7:0] HourBits  = 8'h7F;

  localparam int unsigned IdlePct       = 18;
  localparam int unsigned CalendarItems = 1200;
  localparam int unsigned SteadyItems   = 350;
  localparam int unsigned NoiseItems    = 300;
  localparam int unsigned TailCycles    = 12;
  localparam int unsigned CycleLimit    = 200000;

  typedef struct packed {
    logic        ok;
    logic [14:0] cal_year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } datetime_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;

  datetime_t   expected_dates[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          steady_flow;

  rtc_register_datetime_decode dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Weight the two nibbles as they stand, even when a digit is above nine.
  function automatic int unsigned bcd_weight(input int unsigned v);
    return ((v >> 4) & 15) * 10 + (v & 15);
  endfunction

  // Gregorian month length; zero for a month outside 1..12.
  function automatic int unsigned month_length(input int unsigned yr, input int unsigned mon);
    bit leap_yr;
    leap_yr = (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
    case (mon)
      2:           return leap_yr ? 29 : 28;
      4, 6, 9, 11: return 30;
      1, 3, 5, 7, 8, 10, 12: return 31;
      default:     return 0;
    endcase
  endfunction

  // Decode one register snapshot into the calendar result it must give.
  function automatic datetime_t decode_snapshot(input logic [55:0] regs, input logic [1:0] mode);
    int unsigned sec, minute_v, hour_v, day_v, mon_v, yr_v, cent_v, fy, dim;
    bit          bin, h24, pm;
    datetime_t   r;
    sec      = 32'(regs[7:0]);
    minute_v = 32'(regs[15:8]);
    hour_v   = 32'(regs[23:16]);
    day_v    = 32'(regs[31:24]);
    mon_v    = 32'(regs[39:32]);
    yr_v     = 32'(regs[47:40]);
    cent_v   = 32'(regs[55:48]);
    bin      = mode[0];
    h24      = mode[1];
    pm       = 1'b0;
    r        = '0;
    if (!h24) begin
      pm     = (hour_v & PmFlag) != 0;
      hour_v = hour_v & HourBits;
    end
    if (!bin) begin
      sec      = bcd_weight(sec);
      minute_v = bcd_weight(minute_v);
      hour_v   = bcd_weight(hour_v);
      day_v    = bcd_weight(day_v);
      mon_v    = bcd_weight(mon_v);
      yr_v     = bcd_weight(yr_v);
      if (cent_v != 0) cent_v = bcd_weight(cent_v);
    end
    // Twelve o'clock folds: 12 AM is midnight, PM adds twelve below noon.
    if (!h24) begin
      if (pm) begin
        if (hour_v < 12) hour_v += 12;
      end else if (hour_v == 12) begin
        hour_v = 0;
      end
    end
    fy  = (cent_v != 0) ? cent_v * 100 + yr_v : 2000 + yr_v;
    dim = month_length(fy, mon_v);
    if (dim != 0 && day_v >= 1 && day_v <= dim && hour_v <= 23 &&
        minute_v <= 59 && sec <= 59) begin
      r.ok        = 1'b1;
      r.cal_year  = fy[14:0];
      r.month     = mon_v[3:0];
      r.day       = day_v[4:0];
      r.hour      = hour_v[4:0];
      r.minute    = minute_v[5:0];
      r.second    = sec[5:0];
    end
    return r;
  endfunction

  function automatic logic [55:0] pack_regs(input logic [7:0] sec, input logic [7:0] minute_b,
                                            input logic [7:0] hour_b, input logic [7:0] day_b,
                                            input logic [7:0] mon_b, input logic [7:0] yr_b,
                                            input logic [7:0] cent_b);
    return {cent_b, yr_b, mon_b, day_b, hour_b, minute_b, sec};
  endfunction

  // Register byte for a value, in BCD unless binary format is selected.
  function automatic logic [7:0] to_register_byte(input int unsigned v, input bit bin);
    logic [7:0] b;
    b = bin ? v[7:0] : 8'(((v / 10) << 4) | (v % 10));
    return b;
  endfunction

  // Build one snapshot: noise at the given percentage, else a real calendar reading, some corrupted.
  task automatic pick_snapshot(input int unsigned noise_pct, output logic [55:0] regs,
                               output logic [1:0] mode);
    int unsigned sec, minute_v, hour_v, h12, day_v, mon_v, yr_v, cent_v, fy, dim, k;
    logic [7:0]  hour_b;
    bit          bin, h24;
    if ($urandom_range(99) < noise_pct) begin
      regs = 56'({$urandom, $urandom});
      mode = 2'($urandom_range(3));
    end else begin
      bin  = 1'($urandom_range(1));
      h24  = 1'($urandom_range(1));
      mode = {h24, bin};
      case ($urandom_range(3))
        0:       cent_v = 0;
        1:       cent_v = $urandom_range(19, 21);
        default: cent_v = bin ? $urandom_range(1, 255) : $urandom_range(1, 99);
      endcase
      if ($urandom_range(3) == 0) yr_v = 0;
      else if (bin && $urandom_range(7) == 0) yr_v = $urandom_range(255);
      else yr_v = $urandom_range(99);
      mon_v    = ($urandom_range(3) == 0) ? 2 : $urandom_range(1, 12);
      fy       = (cent_v != 0) ? cent_v * 100 + yr_v : 2000 + yr_v;
      dim      = month_length(fy, mon_v);
      day_v    = ($urandom_range(3) == 0) ? dim : $urandom_range(1, dim);
      hour_v   = $urandom_range(23);
      minute_v = $urandom_range(59);
      sec      = $urandom_range(59);
      if (h24) begin
        hour_b = to_register_byte(hour_v, bin);
      end else begin
        h12    = (hour_v % 12 == 0) ? 12 : hour_v % 12;
        hour_b = to_register_byte(h12, bin) | ((hour_v >= 12) ? PmFlag : 8'h00);
      end
      regs = pack_regs(to_register_byte(sec, bin), to_register_byte(minute_v, bin), hour_b,
                       to_register_byte(day_v, bin), to_register_byte(mon_v, bin),
                       to_register_byte(yr_v, bin), to_register_byte(cent_v, bin));
      // Now and then break one byte or one mode flag of a good reading.
      if ($urandom_range(99) < 20) begin
        k = $urandom_range(7);
        if (k == 7) mode[$urandom_range(1)] = ~mode[$urandom_range(1)];
        else regs[k*8 +: 8] = 8'($urandom_range(255));
      end
    end
  endtask

  // Offer one request and hold it until the block takes it.
  task automatic send_snapshot(input logic [55:0] regs, input logic [1:0] mode);
    if (!steady_flow && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < IdlePct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= regs;
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop offering requests until every expected result has come back.
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_dates.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_cases();
    // Extremes of every byte.
    send_snapshot(pack_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), BcdHour12);
    send_snapshot(pack_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), BinHour24);
    send_snapshot(pack_regs(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 8'h20), BcdHour24);
    // Twelve-hour mapping around midnight and noon.
    send_snapshot(pack_regs(8'h00, 8'h00, 8'h12, 8'h01, 8'h01, 8'h24, 8'h20), BcdHour12);
    send_snapshot(pack_regs(8'h00, 8'h00, 8'h92, 8'h01, 8'h01, 8'h24, 8'h20), BcdHour12);
    send_snapshot(pack_regs(8'h00, 8'h00, 8'h91, 8'h01, 8'h01, 8'h24, 8'h20), BcdHour12);
    send_snapshot(pack_regs(8'h00, 8'h00, 8'h93, 8'h01, 8'h01, 8'h24, 8'h20), BcdHour12);
    send_snapshot(pack_regs(8'h00, 8'h00, 8'h80, 8'h01, 8'h01, 8'h24, 8'h20), BcdHour12);
    send_snapshot(pack_regs(8'h00, 8'h00, 8'h13, 8'h01, 8'h01, 8'h24, 8'h20), BcdHour12);
    send_snapshot(pack_regs(8'h00, 8'h00, 8'h8C, 8'h01, 8'h01, 8'h18, 8'h00), BinHour12);
    // In 24-hour mode the top hour bit stays and makes the hour fail.
    send_snapshot(pack_regs(8'h00, 8'h00, 8'h85, 8'h01, 8'h01, 8'h24, 8'h20), BcdHour24);
    send_snapshot(pack_regs(8'h00, 8'h00, 8'h85, 8'h01, 8'h01, 8'h18, 8'h00), BinHour24);
    // Nibbles above nine are weighted as they stand.
    send_snapshot(pack_regs(8'h0F, 8'h1A, 8'h10, 8'h15, 8'h06, 8'h24, 8'h20), BcdHour24);
    send_snapshot(pack_regs(8'hFA, 8'h00, 8'h10, 8'h15, 8'h06, 8'h24, 8'h20), BcdHour24);
    // Leap day across the century rule, with and without a century byte.
    send_snapshot(pack_regs(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h00, 8'h20), BcdHour24);
    send_snapshot(pack_regs(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h00, 8'h19), BcdHour24);
    send_snapshot(pack_regs(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h00, 8'h21), BcdHour24);
    send_snapshot(pack_regs(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h24, 8'h00), BcdHour24);
    send_snapshot(pack_regs(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h23, 8'h00), BcdHour24);
    // Month and time limits.
    send_snapshot(pack_regs(8'h00, 8'h00, 8'h00, 8'h31, 8'h04, 8'h24, 8'h20), BcdHour24);
    send_snapshot(pack_regs(8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h24, 8'h20), BcdHour24);
    send_snapshot(pack_regs(8'h60, 8'h00, 8'h00, 8'h01, 8'h01, 8'h24, 8'h20), BcdHour24);
    send_snapshot(pack_regs(8'h00, 8'h60, 8'h00, 8'h01, 8'h01, 8'h24, 8'h20), BcdHour24);
    send_snapshot(pack_regs(8'h00, 8'h00, 8'h24, 8'h01, 8'h01, 8'h24, 8'h20), BcdHour24);
    // Binary format at the top of the year range.
    send_snapshot(pack_regs(8'd59, 8'd59, 8'd23, 8'd31, 8'd12, 8'd99, 8'd255), BinHour24);
    send_snapshot(pack_regs(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd255, 8'd0), BinHour24);
  endtask

  // Mostly good readings; halfway through the sender waits for a full drain.
  task automatic test_random_calendar();
    logic [55:0] regs;
    logic [1:0]  mode;
    for (int unsigned i = 0; i < CalendarItems; i++) begin
      if (i == CalendarItems / 2) wait_for_drain();
      pick_snapshot(10, regs, mode);
      send_snapshot(regs, mode);
    end
  endtask

  // A long stretch where neither side idles.
  task automatic test_back_to_back();
    logic [55:0] regs;
    logic [1:0]  mode;
    steady_flow = 1'b1;
    for (int unsigned i = 0; i < SteadyItems; i++) begin
      pick_snapshot(30, regs, mode);
      send_snapshot(regs, mode);
    end
    steady_flow = 1'b0;
  endtask

  task automatic test_random_noise();
    logic [55:0] regs;
    logic [1:0]  mode;
    for (int unsigned i = 0; i < NoiseItems; i++) begin
      pick_snapshot(100, regs, mode);
      send_snapshot(regs, mode);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Output stall pattern.
  always @(posedge clk_i) begin
    m_axis_tready <= steady_flow || ($urandom_range(99) >= IdlePct);
  end

  // Record each accepted request and check each accepted result.
  always @(posedge clk_i) begin : scoreboard
    datetime_t want;
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      expected_dates.push_back(decode_snapshot(s_axis_tdata, s_axis_tuser));
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_dates.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got %h/%b", $time, m_axis_tdata,
                 m_axis_tuser);
      end else begin
        want = expected_dates.pop_front();
        check_field("ok",       32'(want.ok),       32'(m_axis_tuser));
        check_field("cal_year", 32'(want.cal_year), 32'(m_axis_tdata[14:0]));
        check_field("month",    32'(want.month),    32'(m_axis_tdata[18:15]));
        check_field("day",      32'(want.day),      32'(m_axis_tdata[23:19]));
        check_field("hour",     32'(want.hour),     32'(m_axis_tdata[28:24]));
        check_field("minute",   32'(want.minute),   32'(m_axis_tdata[34:29]));
        check_field("second",   32'(want.second),   32'(m_axis_tdata[40:35]));
        check_field("pad",      32'd0,              32'(m_axis_tdata[47:41]));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    mismatches    = 0;
    cycle_count   = 0;
    steady_flow   = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_random_calendar();
    test_back_to_back();
    test_random_noise();
    wait_for_drain();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
